// ===== hw/rtl/pidc_pkg.sv =====
// ----------------------------------------------------------------------------
// pidc_pkg: shared types and constants for the pixel interlace depth converter
// Payload structs, register indexes, lane mode codes and the small helper
// functions used by the front end and the scaling lanes.
// ----------------------------------------------------------------------------
package pidc_pkg;

	localparam int NUM_LANES   = 4;
	localparam int CHANNELS    = 4;
	localparam int SAMPLE_BITS = 16;
	localparam int SAMPLE_W    = 16;
	localparam int CFG_W       = 13;
	localparam int BITS_W      = 5;
	localparam int CHAN_W      = 3;
	localparam int CFG_IDX_W   = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_BAND     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COL_BAND     = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A_BITS       = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B_BITS       = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_A_CHANNELS   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_B_CHANNELS   = 4'd7;

	// what a lane produces for the current pixel
	localparam logic [1:0] LANE_ZERO  = 2'd0;
	localparam logic [1:0] LANE_FILL  = 2'd1;
	localparam logic [1:0] LANE_PASS  = 2'd2;
	localparam logic [1:0] LANE_SCALE = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] a_ch0;
		logic [SAMPLE_W-1:0] a_ch1;
		logic [SAMPLE_W-1:0] a_ch2;
		logic [SAMPLE_W-1:0] a_ch3;
		logic [SAMPLE_W-1:0] b_ch0;
		logic [SAMPLE_W-1:0] b_ch1;
		logic [SAMPLE_W-1:0] b_ch2;
		logic [SAMPLE_W-1:0] b_ch3;
	} pix_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_c0;
		logic [SAMPLE_W-1:0] out_c1;
		logic [SAMPLE_W-1:0] out_c2;
		logic [SAMPLE_W-1:0] out_c3;
		logic                from_first;
		logic                end_of_row;
		logic                end_of_frame;
	} pix_out_t;

	typedef struct packed {
		logic [CFG_W-1:0]  image_width;
		logic [CFG_W-1:0]  image_height;
		logic [CFG_W-1:0]  row_band;
		logic [CFG_W-1:0]  col_band;
		logic [BITS_W-1:0] a_bits;
		logic [BITS_W-1:0] b_bits;
		logic [CHAN_W-1:0] a_channels;
		logic [CHAN_W-1:0] b_channels;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [BITS_W-1:0] sbits;
		logic [BITS_W-1:0] dbits;
	} lane_ctl_t;

	typedef struct packed {
		logic from_first;
		logic end_of_row;
		logic end_of_frame;
	} flags_t;

	function automatic logic [BITS_W-1:0] clamp_bits(input logic [BITS_W-1:0] b);
		logic [BITS_W-1:0] r;
		if (b == '0)
			r = BITS_W'(1);
		else if (b > BITS_W'(SAMPLE_BITS))
			r = BITS_W'(SAMPLE_BITS);
		else
			r = b;
		return r;
	endfunction

	function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CHAN_W-1:0] c);
		logic [CHAN_W-1:0] r;
		if (c == '0)
			r = CHAN_W'(1);
		else if (c > CHAN_W'(CHANNELS))
			r = CHAN_W'(CHANNELS);
		else
			r = c;
		return r;
	endfunction

	// (2^bits)-1 for bits in 1..16
	function automatic logic [SAMPLE_W-1:0] full_scale(input logic [BITS_W-1:0] b);
		logic [SAMPLE_W:0] t;
		t = ({{SAMPLE_W{1'b0}}, 1'b1} << b) - {{SAMPLE_W{1'b0}}, 1'b1};
		return t[SAMPLE_W-1:0];
	endfunction

	// floor(2^32 / (2^bits - 1)), except bits=1 which holds 2^32-1;
	// the quotient estimate is at most one low and gets corrected later
	function automatic logic [31:0] recip(input logic [BITS_W-1:0] b);
		logic [31:0] r;
		case (b)
			5'd1:    r = 32'hFFFF_FFFF;
			5'd2:    r = 32'h5555_5555;
			5'd3:    r = 32'h2492_4924;
			5'd4:    r = 32'h1111_1111;
			5'd5:    r = 32'h0842_1084;
			5'd6:    r = 32'h0410_4104;
			5'd7:    r = 32'h0204_0810;
			5'd8:    r = 32'h0101_0101;
			5'd9:    r = 32'h0080_4020;
			5'd10:   r = 32'h0040_1004;
			5'd11:   r = 32'h0020_0400;
			5'd12:   r = 32'h0010_0100;
			5'd13:   r = 32'h0008_0040;
			5'd14:   r = 32'h0004_0010;
			5'd15:   r = 32'h0002_0004;
			5'd16:   r = 32'h0001_0001;
			default: r = 32'h0000_0000;
		endcase
		return r;
	endfunction

endpackage

// ===== hw/rtl/pixel_interlace_depth_convert.sv =====
// ----------------------------------------------------------------------------
// pixel_interlace_depth_convert: two-image pixel interleaver with depth scaling
// Usage: feed co-located pixel pairs of images A and B in raster order on the
// in_valid/in_ready channel; one output pixel per input comes back on the
// out_valid/out_ready channel with its source and end-of-row/frame flags.
// Configuration goes through cfg_valid/cfg_index/cfg_data (cfg_ready is
// always high); the user must change it only while no pixel is in flight,
// as the block itself does not enforce this. Pipeline: a pixel accepted
// at one clock edge is loaded into the front register, then passes the three
// lane stages and the output register before it is presented on the output.
// Throughput: one pixel per cycle unless the output stalls; every stage is a
// register on one shared enable, so back-to-back transfers flow without gaps.
// Stalls: when the output register is full and out_ready is low the whole
// pipeline holds and in_ready drops in the same cycle.
// Reset: registers return to their defaults (4096x4096, row bands of one
// line, 8-bit three-channel sources) and all raster counters clear.
// ----------------------------------------------------------------------------
module pixel_interlace_depth_convert #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  pidc_pkg::pix_in_t              in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output pidc_pkg::pix_out_t             out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pidc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pidc_pkg::CFG_W-1:0]     cfg_data
);

	pidc_pkg::cfg_t                cfg_q;
	logic                          v_s1, v_s2, v_s3, v_s4, out_valid_q;
	logic                          en, accept;
	logic [pidc_pkg::SAMPLE_W-1:0] x_s1 [pidc_pkg::NUM_LANES];
	pidc_pkg::lane_ctl_t           ctl_s1 [pidc_pkg::NUM_LANES];
	logic [pidc_pkg::SAMPLE_W-1:0] lane_res [pidc_pkg::NUM_LANES];
	pidc_pkg::flags_t              flags_s1, flags_s2, flags_s3, flags_s4;
	pidc_pkg::pix_out_t            out_q;

	assign en        = !out_valid_q || out_ready;
	assign accept    = in_valid && en;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= 13'd4096;
			cfg_q.image_height <= 13'd4096;
			cfg_q.row_band     <= 13'd1;
			cfg_q.col_band     <= 13'd0;
			cfg_q.a_bits       <= 5'd8;
			cfg_q.b_bits       <= 5'd8;
			cfg_q.a_channels   <= 3'd3;
			cfg_q.b_channels   <= 3'd3;
		end else if (cfg_valid) begin
			case (cfg_index)
				pidc_pkg::REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				pidc_pkg::REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				pidc_pkg::REG_ROW_BAND:     cfg_q.row_band     <= cfg_data;
				pidc_pkg::REG_COL_BAND:     cfg_q.col_band     <= cfg_data;
				pidc_pkg::REG_A_BITS:       cfg_q.a_bits       <= cfg_data[4:0];
				pidc_pkg::REG_B_BITS:       cfg_q.b_bits       <= cfg_data[4:0];
				pidc_pkg::REG_A_CHANNELS:   cfg_q.a_channels   <= cfg_data[2:0];
				pidc_pkg::REG_B_CHANNELS:   cfg_q.b_channels   <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	pidc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.en      (en),
		.in_data (in_data),
		.cfg     (cfg_q),
		.x_s1    (x_s1),
		.ctl_s1  (ctl_s1),
		.flags_s1(flags_s1)
	);

	for (genvar g = 0; g < pidc_pkg::NUM_LANES; g++) begin : g_lane
		pidc_lane u_lane (
			.clk   (clk),
			.en    (en),
			.x     (x_s1[g]),
			.ctl   (ctl_s1[g]),
			.result(lane_res[g])
		);
	end

	// valid bits move with the shared stage enable
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= in_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	// merge lanes and flags into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			flags_s2           <= flags_s1;
			flags_s3           <= flags_s2;
			flags_s4           <= flags_s3;
			out_q.out_c0       <= lane_res[0];
			out_q.out_c1       <= lane_res[1];
			out_q.out_c2       <= lane_res[2];
			out_q.out_c3       <= lane_res[3];
			out_q.from_first   <= flags_s4.from_first;
			out_q.end_of_row   <= flags_s4.end_of_row;
			out_q.end_of_frame <= flags_s4.end_of_frame;
		end
	end

endmodule

// ===== hw/rtl/pidc_front.sv =====
// ----------------------------------------------------------------------------
// pidc_front: raster counters, source selection and lane setup
// Tracks column, row and band positions, picks image A or B per pixel, clamps
// the chosen samples and registers them with a per-lane mode into stage 1.
// ----------------------------------------------------------------------------
module pidc_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          en,
	input  pidc_pkg::pix_in_t             in_data,
	input  pidc_pkg::cfg_t                cfg,
	output logic [pidc_pkg::SAMPLE_W-1:0] x_s1 [pidc_pkg::NUM_LANES],
	output pidc_pkg::lane_ctl_t           ctl_s1 [pidc_pkg::NUM_LANES],
	output pidc_pkg::flags_t              flags_s1
);

	localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int MW0 = (CW > RW) ? CW : RW;
	localparam int KW  = ((MW0 > pidc_pkg::CFG_W) ? MW0 : pidc_pkg::CFG_W) + 1;

	logic [CW-1:0] col_pos_q, col_band_cnt_q;
	logic [RW-1:0] row_pos_q, row_band_cnt_q;
	logic          col_par_q, row_par_q;

	logic [KW-1:0] w_lim, h_lim, col_inc, row_inc, cbc_inc, rbc_inc;
	logic [pidc_pkg::BITS_W-1:0] ab, bb, dbits, sbits;
	logic [pidc_pkg::CHAN_W-1:0] ac, bc, dch, sch;
	logic [pidc_pkg::SAMPLE_W-1:0] smax;
	logic [pidc_pkg::SAMPLE_W-1:0] a_s [pidc_pkg::NUM_LANES];
	logic [pidc_pkg::SAMPLE_W-1:0] b_s [pidc_pkg::NUM_LANES];
	logic [pidc_pkg::SAMPLE_W-1:0] x_d [pidc_pkg::NUM_LANES];
	pidc_pkg::lane_ctl_t           ctl_d [pidc_pkg::NUM_LANES];
	logic use_a, row_mode, col_mode, eor, eof;
	logic [CW-1:0] cbc_next;
	logic          cpar_next;
	logic [RW-1:0] rbc_next;
	logic          rpar_next;

	always_comb begin
		if (cfg.image_width == '0)
			w_lim = KW'(1);
		else if (KW'(cfg.image_width) > KW'(MAX_WIDTH))
			w_lim = KW'(MAX_WIDTH);
		else
			w_lim = KW'(cfg.image_width);
		if (cfg.image_height == '0)
			h_lim = KW'(1);
		else if (KW'(cfg.image_height) > KW'(MAX_HEIGHT))
			h_lim = KW'(MAX_HEIGHT);
		else
			h_lim = KW'(cfg.image_height);

		ab    = pidc_pkg::clamp_bits(cfg.a_bits);
		bb    = pidc_pkg::clamp_bits(cfg.b_bits);
		ac    = pidc_pkg::clamp_chan(cfg.a_channels);
		bc    = pidc_pkg::clamp_chan(cfg.b_channels);
		dbits = (ab > bb) ? ab : bb;
		dch   = (ac > bc) ? ac : bc;

		row_mode = |cfg.row_band;
		col_mode = |cfg.col_band;
		if (row_mode && col_mode)
			use_a = (row_par_q == col_par_q);
		else if (row_mode)
			use_a = !row_par_q;
		else if (col_mode)
			use_a = !col_par_q;
		else
			use_a = 1'b1;

		sbits = use_a ? ab : bb;
		sch   = use_a ? ac : bc;
		smax  = pidc_pkg::full_scale(sbits);

		a_s[0] = in_data.a_ch0;
		a_s[1] = in_data.a_ch1;
		a_s[2] = in_data.a_ch2;
		a_s[3] = in_data.a_ch3;
		b_s[0] = in_data.b_ch0;
		b_s[1] = in_data.b_ch1;
		b_s[2] = in_data.b_ch2;
		b_s[3] = in_data.b_ch3;

		for (int i = 0; i < pidc_pkg::NUM_LANES; i++) begin
			x_d[i] = use_a ? a_s[i] : b_s[i];
			if (x_d[i] > smax)
				x_d[i] = smax;
			ctl_d[i].sbits = sbits;
			ctl_d[i].dbits = dbits;
			if (pidc_pkg::CHAN_W'(i) >= dch)
				ctl_d[i].mode = pidc_pkg::LANE_ZERO;
			else if (pidc_pkg::CHAN_W'(i) >= sch)
				ctl_d[i].mode = pidc_pkg::LANE_FILL;
			else if (sbits == dbits)
				ctl_d[i].mode = pidc_pkg::LANE_PASS;
			else
				ctl_d[i].mode = pidc_pkg::LANE_SCALE;
		end

		col_inc = KW'(col_pos_q) + KW'(1);
		row_inc = KW'(row_pos_q) + KW'(1);
		eor     = col_inc >= w_lim;
		eof     = eor && (row_inc >= h_lim);

		// band counters: wrap and flip parity when the band is used up
		cbc_inc   = KW'(col_band_cnt_q) + KW'(1);
		cpar_next = col_par_q;
		if (!col_mode)
			cbc_next = '0;
		else if (cbc_inc >= KW'(cfg.col_band)) begin
			cbc_next  = '0;
			cpar_next = !col_par_q;
		end else
			cbc_next = cbc_inc[CW-1:0];

		rbc_inc   = KW'(row_band_cnt_q) + KW'(1);
		rpar_next = row_par_q;
		if (!row_mode)
			rbc_next = '0;
		else if (rbc_inc >= KW'(cfg.row_band)) begin
			rbc_next  = '0;
			rpar_next = !row_par_q;
		end else
			rbc_next = rbc_inc[RW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q      <= '0;
			row_pos_q      <= '0;
			col_band_cnt_q <= '0;
			row_band_cnt_q <= '0;
			col_par_q      <= 1'b0;
			row_par_q      <= 1'b0;
		end else if (accept) begin
			if (!eor) begin
				col_pos_q      <= col_inc[CW-1:0];
				col_band_cnt_q <= cbc_next;
				col_par_q      <= cpar_next;
			end else begin
				col_pos_q      <= '0;
				col_band_cnt_q <= '0;
				col_par_q      <= 1'b0;
				if (eof) begin
					row_pos_q      <= '0;
					row_band_cnt_q <= '0;
					row_par_q      <= 1'b0;
				end else begin
					row_pos_q      <= row_inc[RW-1:0];
					row_band_cnt_q <= rbc_next;
					row_par_q      <= rpar_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1                  <= x_d;
			ctl_s1                <= ctl_d;
			flags_s1.from_first   <= use_a;
			flags_s1.end_of_row   <= eor;
			flags_s1.end_of_frame <= eof;
		end
	end

endmodule

// ===== hw/rtl/pidc_lane.sv =====
// ----------------------------------------------------------------------------
// pidc_lane: one sample lane of the depth converter
// Per mode gives 0, dmax, x or round(x * dmax / smax), the last by reciprocal
// multiply and a one-step quotient correction, over three registered stages.
// ----------------------------------------------------------------------------
module pidc_lane (
	input  logic                          clk,
	input  logic                          en,
	input  logic [pidc_pkg::SAMPLE_W-1:0] x,
	input  pidc_pkg::lane_ctl_t           ctl,
	output logic [pidc_pkg::SAMPLE_W-1:0] result
);

	pidc_pkg::lane_ctl_t           ctl_s2, ctl_s3, ctl_s4;
	logic [pidc_pkg::SAMPLE_W-1:0] x_s2, x_s3, x_s4;
	logic [31:0]                   n_s2, n_s3, n_s4, qm_s4;
	logic [pidc_pkg::SAMPLE_W-1:0] q_s3, q_s4;

	logic [pidc_pkg::SAMPLE_W-1:0] smax_in, dmax_in, smax_s3, smax_s4;
	logic [31:0]                   prod1, rem;
	logic [63:0]                   prod2;
	logic [pidc_pkg::SAMPLE_W-1:0] q_fix;

	always_comb begin
		smax_in = pidc_pkg::full_scale(ctl.sbits);
		dmax_in = pidc_pkg::full_scale(ctl.dbits);
		// numerator with the rounding term folded in
		prod1   = 32'(x) * 32'(dmax_in) + 32'(smax_in[pidc_pkg::SAMPLE_W-1:1]);
		prod2   = 64'(n_s2) * 64'(pidc_pkg::recip(ctl_s2.sbits));
		smax_s3 = pidc_pkg::full_scale(ctl_s3.sbits);
		smax_s4 = pidc_pkg::full_scale(ctl_s4.sbits);
		rem     = n_s4 - qm_s4;
		q_fix   = (rem >= 32'(smax_s4)) ? q_s4 + 16'd1 : q_s4;
		case (ctl_s4.mode)
			pidc_pkg::LANE_ZERO:  result = '0;
			pidc_pkg::LANE_FILL:  result = pidc_pkg::full_scale(ctl_s4.dbits);
			pidc_pkg::LANE_PASS:  result = x_s4;
			pidc_pkg::LANE_SCALE: result = q_fix;
			default:              result = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl;
			x_s2   <= x;
			n_s2   <= prod1;

			ctl_s3 <= ctl_s2;
			x_s3   <= x_s2;
			n_s3   <= n_s2;
			q_s3   <= prod2[47:32];

			ctl_s4 <= ctl_s3;
			x_s4   <= x_s3;
			n_s4   <= n_s3;
			q_s4   <= q_s3;
			qm_s4  <= 32'(q_s3) * 32'(smax_s3);
		end
	end

endmodule
